/* src/lewr_pkg.sv */
`timescale 1ns / 1ps
package lewr_pkg;

    // line store geometry
    localparam int LINE_DEPTH  = 48;
    localparam int CUR_W       = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(LINE_DEPTH);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int WCOL_W      = 6;
    localparam int CFG_IDX_W   = 3;

    typedef logic [CUR_W-1:0]     t_cur;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [QPTR_W-1:0]    t_qptr;
    typedef logic [QCNT_W-1:0]    t_qcnt;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [COUNT_W-1:0]   t_cnt;
    typedef logic [WCOL_W-1:0]    t_wcol;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // character codes
    localparam t_byte SPACE_BYTE   = 8'h20;
    localparam t_byte NEWLINE_BYTE = 8'h0A;
    localparam t_byte PRINT_LO     = 8'h20;
    localparam t_byte PRINT_HI     = 8'h7E;

    // register indexes
    localparam t_cfg_idx CFG_EOF    = 3'd0;
    localparam t_cfg_idx CFG_ERASE  = 3'd1;
    localparam t_cfg_idx CFG_KILL   = 3'd2;
    localparam t_cfg_idx CFG_WERASE = 3'd3;
    localparam t_cfg_idx CFG_WRAP   = 3'd4;

    // register reset values
    localparam t_byte RST_EOF    = 8'd4;
    localparam t_byte RST_ERASE  = 8'd127;
    localparam t_byte RST_KILL   = 8'd21;
    localparam t_byte RST_WERASE = 8'd23;
    localparam t_wcol RST_WRAP   = 6'd40;

    // edit actions
    typedef enum logic [2:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_BELL    = 3'd2,
        ACT_NEWLINE = 3'd3,
        ACT_END     = 3'd4
    } t_action;

    // editing registers
    typedef struct packed {
        t_byte eof_char;
        t_byte erase_char;
        t_byte kill_char;
        t_byte word_erase_char;
        t_wcol wrap_column;
    } t_cfg;

    // classified item as queued between front and back
    typedef struct packed {
        t_byte data;
        logic  is_eof;
        logic  is_erase;
        logic  is_kill;
        logic  is_werase;
        logic  is_nl;
        logic  is_print;
        logic  is_space;
    } t_item;

endpackage

/* src/lewr_ram.sv */
`timescale 1ns / 1ps
module lewr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lewr_front.sv */
`timescale 1ns / 1ps
module lewr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lewr_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  lewr_pkg::t_byte i_byte,
    output logic           o_q_valid,
    output lewr_pkg::t_item o_q_item,
    input  logic           i_q_pop
);

    lewr_pkg::t_item r_q [lewr_pkg::QUEUE_DEPTH];
    lewr_pkg::t_qptr r_wr;
    lewr_pkg::t_qptr r_rd;
    lewr_pkg::t_qcnt r_cnt;
    lewr_pkg::t_item cls;
    logic            push;
    logic            pop;

    // classify the incoming byte against the editing registers
    always_comb begin
        cls.data      = i_byte;
        cls.is_eof    = (i_byte == i_cfg.eof_char);
        cls.is_erase  = (i_byte == i_cfg.erase_char);
        cls.is_kill   = (i_byte == i_cfg.kill_char);
        cls.is_werase = (i_byte == i_cfg.word_erase_char);
        cls.is_nl     = (i_byte == lewr_pkg::NEWLINE_BYTE);
        cls.is_print  = (i_byte >= lewr_pkg::PRINT_LO) && (i_byte <= lewr_pkg::PRINT_HI);
        cls.is_space  = (i_byte == lewr_pkg::SPACE_BYTE);
    end

    assign o_ready   = (r_cnt != lewr_pkg::t_qcnt'(lewr_pkg::QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == lewr_pkg::t_qptr'(lewr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == lewr_pkg::t_qptr'(lewr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/lewr_back.sv */
`timescale 1ns / 1ps
module lewr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lewr_pkg::t_wcol   i_wrap_col,
    input  logic              i_q_valid,
    input  lewr_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_action,
    output lewr_pkg::t_byte   o_echo_byte,
    output lewr_pkg::t_cnt    o_erase_count,
    output logic              o_last
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_EMIT = 8'b0000_0010,
        ST_RD   = 8'b0000_0100,
        ST_CHK  = 8'b0000_1000,
        ST_DONE = 8'b0001_0000,
        ST_NL   = 8'b0010_0000,
        ST_CRD  = 8'b0100_0000,
        ST_ECHO = 8'b1000_0000
    } t_state;

    t_state            r_state,  n_state;
    t_state            r_after,  n_after;
    lewr_pkg::t_cur    r_cursor, n_cursor;
    lewr_pkg::t_cur    r_pos,    n_pos;
    logic              r_phase,  n_phase;
    logic              r_kind_wrap, n_kind_wrap;
    logic              r_nsp,    n_nsp;
    lewr_pkg::t_cur    r_start,  n_start;
    lewr_pkg::t_cur    r_len,    n_len;
    lewr_pkg::t_cur    r_idx,    n_idx;
    lewr_pkg::t_action r_em_action, n_em_action;
    lewr_pkg::t_byte   r_em_byte,   n_em_byte;
    lewr_pkg::t_cur    r_em_count,  n_em_count;
    logic              r_em_last,   n_em_last;

    logic              r_out_valid, n_out_valid;
    lewr_pkg::t_action r_out_action, n_out_action;
    lewr_pkg::t_byte   r_out_byte,   n_out_byte;
    lewr_pkg::t_cnt    r_out_count,  n_out_count;
    logic              r_out_last,   n_out_last;

    logic              can_emit;
    logic              l_prim;
    logic              l_wrap;
    lewr_pkg::t_cur    l_new_cur;
    logic              ram_we;
    lewr_pkg::t_addr   ram_waddr;
    lewr_pkg::t_byte   ram_wdata;
    logic              ram_re;
    lewr_pkg::t_addr   ram_raddr;
    lewr_pkg::t_byte   ram_rdata;

    lewr_ram #(
        .WIDTH (lewr_pkg::BYTE_W),
        .DEPTH (lewr_pkg::LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register frees up when empty or being taken
    assign can_emit = !r_out_valid || i_out_ready;

    // edit sequencer
    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_cursor     = r_cursor;
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_kind_wrap  = r_kind_wrap;
        n_nsp        = r_nsp;
        n_start      = r_start;
        n_len        = r_len;
        n_idx        = r_idx;
        n_em_action  = r_em_action;
        n_em_byte    = r_em_byte;
        n_em_count   = r_em_count;
        n_em_last    = r_em_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_action = r_out_action;
        n_out_byte   = r_out_byte;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        l_prim       = 1'b0;
        l_wrap       = 1'b0;
        l_new_cur    = r_cursor;
        ram_we       = 1'b0;
        ram_waddr    = lewr_pkg::t_addr'(r_cursor);
        ram_wdata    = i_q_item.data;
        ram_re       = 1'b0;
        ram_raddr    = lewr_pkg::t_addr'(r_pos - lewr_pkg::t_cur'(1));

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_nsp       = !i_q_item.is_space;
                    n_em_byte   = '0;
                    n_em_count  = '0;
                    n_state     = ST_EMIT;
                    l_prim      = 1'b1;
                    if (i_q_item.is_eof && (r_cursor == '0)) begin
                        // end of input on an empty line, no wrap check
                        l_prim      = 1'b0;
                        n_em_action = lewr_pkg::ACT_END;
                        n_em_last   = 1'b1;
                        n_after     = ST_IDLE;
                    end else if (i_q_item.is_erase && (r_cursor != '0)) begin
                        l_new_cur   = r_cursor - lewr_pkg::t_cur'(1);
                        n_em_action = lewr_pkg::ACT_ERASE;
                        n_em_count  = lewr_pkg::t_cur'(1);
                    end else if (i_q_item.is_kill && (r_cursor != '0)) begin
                        l_new_cur   = '0;
                        n_em_action = lewr_pkg::ACT_ERASE;
                        n_em_count  = r_cursor;
                    end else if (i_q_item.is_werase && (r_cursor != '0)) begin
                        // skip trailing spaces, then the word
                        l_prim      = 1'b0;
                        n_pos       = r_cursor;
                        n_phase     = 1'b0;
                        n_kind_wrap = 1'b0;
                        n_state     = ST_RD;
                    end else if (i_q_item.is_nl) begin
                        l_new_cur   = '0;
                        n_em_action = lewr_pkg::ACT_NEWLINE;
                    end else if (!i_q_item.is_print ||
                                 (r_cursor >= lewr_pkg::t_cur'(lewr_pkg::LINE_DEPTH))) begin
                        n_em_action = lewr_pkg::ACT_BELL;
                    end else begin
                        ram_we      = 1'b1;
                        l_new_cur   = r_cursor + lewr_pkg::t_cur'(1);
                        n_em_action = lewr_pkg::ACT_ECHO;
                        n_em_byte   = i_q_item.data;
                    end
                    if (l_prim) begin
                        l_wrap      = !i_q_item.is_space &&
                                      (int'(l_new_cur) >= int'(i_wrap_col));
                        n_cursor    = l_new_cur;
                        n_em_last   = !l_wrap;
                        n_after     = l_wrap ? ST_RD : ST_IDLE;
                        n_pos       = l_new_cur;
                        n_phase     = 1'b1;
                        n_kind_wrap = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_action = r_em_action;
                    n_out_byte   = r_em_byte;
                    n_out_count  = lewr_pkg::t_cnt'(r_em_count);
                    n_out_last   = r_em_last;
                    n_state      = r_after;
                end
            end
            ST_RD: begin
                if (r_pos == '0) begin
                    n_state = ST_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (!r_phase) begin
                    // trailing spaces phase ends at the first non-space
                    n_pos   = r_pos - lewr_pkg::t_cur'(1);
                    n_phase = (ram_rdata != lewr_pkg::SPACE_BYTE);
                    n_state = ST_RD;
                end else if (ram_rdata != lewr_pkg::SPACE_BYTE) begin
                    n_pos   = r_pos - lewr_pkg::t_cur'(1);
                    n_state = ST_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_em_byte  = '0;
                n_em_count = '0;
                if (!r_kind_wrap) begin
                    // word erase result, then wrap check on the new cursor
                    l_wrap      = r_nsp && (int'(r_pos) >= int'(i_wrap_col));
                    n_em_action = lewr_pkg::ACT_ERASE;
                    n_em_count  = r_cursor - r_pos;
                    n_em_last   = !l_wrap;
                    n_after     = l_wrap ? ST_RD : ST_IDLE;
                    n_cursor    = r_pos;
                    n_phase     = 1'b1;
                    n_kind_wrap = 1'b1;
                    n_state     = ST_EMIT;
                end else if (r_pos == '0) begin
                    // no space on the line: bare newline
                    n_em_action = lewr_pkg::ACT_NEWLINE;
                    n_em_last   = 1'b1;
                    n_after     = ST_IDLE;
                    n_cursor    = '0;
                    n_state     = ST_EMIT;
                end else begin
                    n_start  = r_pos;
                    n_len    = r_cursor - r_pos;
                    n_idx    = '0;
                    n_cursor = r_cursor - r_pos;
                    if (r_cursor != r_pos) begin
                        n_em_action = lewr_pkg::ACT_ERASE;
                        n_em_count  = r_cursor - r_pos;
                        n_em_last   = 1'b0;
                        n_after     = ST_NL;
                        n_state     = ST_EMIT;
                    end else begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_NL: begin
                n_em_action = lewr_pkg::ACT_NEWLINE;
                n_em_byte   = '0;
                n_em_count  = '0;
                n_em_last   = (r_len == '0);
                n_after     = (r_len == '0) ? ST_IDLE : ST_CRD;
                n_state     = ST_EMIT;
            end
            ST_CRD: begin
                ram_re    = 1'b1;
                ram_raddr = lewr_pkg::t_addr'(r_start + r_idx);
                n_state   = ST_ECHO;
            end
            ST_ECHO: begin
                // echo the moved byte and store it at the line start
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_action = lewr_pkg::ACT_ECHO;
                    n_out_byte   = ram_rdata;
                    n_out_count  = '0;
                    n_out_last   = (r_idx == r_len - lewr_pkg::t_cur'(1));
                    ram_we       = 1'b1;
                    ram_waddr    = lewr_pkg::t_addr'(r_idx);
                    ram_wdata    = ram_rdata;
                    n_idx        = r_idx + lewr_pkg::t_cur'(1);
                    n_state      = (r_idx == r_len - lewr_pkg::t_cur'(1)) ? ST_IDLE : ST_CRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= ST_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_phase      <= n_phase;
        r_kind_wrap  <= n_kind_wrap;
        r_nsp        <= n_nsp;
        r_start      <= n_start;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_em_action  <= n_em_action;
        r_em_byte    <= n_em_byte;
        r_em_count   <= n_em_count;
        r_em_last    <= n_em_last;
        r_out_action <= n_out_action;
        r_out_byte   <= n_out_byte;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_echo_byte   = r_out_byte;
    assign o_erase_count = r_out_count;
    assign o_last        = r_out_last;

endmodule

/* src/line_editor_with_word_wrap.sv */
`timescale 1ns / 1ps
// path: a simple byte is queued, taken in ST_IDLE, then passed through ST_EMIT to the output register
// a new queued byte is taken only once all results of the last one are emitted; scans of the
// line store visit each stored byte through ST_RD and ST_CHK, and each re-echoed byte of a wrap
// goes through ST_CRD and ST_ECHO, all set by the single registered read port of the line store
// the longest run is for a printable byte that wraps a line-long word
// reset: synchronous, active low; clears cursor, queue and registers, line store left as is
module line_editor_with_word_wrap (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_typed_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_action,
    output logic [7:0] o_echo_byte,
    output logic [5:0] o_erase_count,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    lewr_pkg::t_cfg  r_cfg;
    logic            q_valid;
    lewr_pkg::t_item q_item;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    // editing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eof_char        <= lewr_pkg::RST_EOF;
            r_cfg.erase_char      <= lewr_pkg::RST_ERASE;
            r_cfg.kill_char       <= lewr_pkg::RST_KILL;
            r_cfg.word_erase_char <= lewr_pkg::RST_WERASE;
            r_cfg.wrap_column     <= lewr_pkg::RST_WRAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lewr_pkg::CFG_EOF:    r_cfg.eof_char        <= i_cfg_data;
                lewr_pkg::CFG_ERASE:  r_cfg.erase_char      <= i_cfg_data;
                lewr_pkg::CFG_KILL:   r_cfg.kill_char       <= i_cfg_data;
                lewr_pkg::CFG_WERASE: r_cfg.word_erase_char <= i_cfg_data;
                lewr_pkg::CFG_WRAP:   r_cfg.wrap_column     <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // accept and classify
    lewr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_byte    (i_typed_byte),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // line store and edit sequencer
    lewr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wrap_col    (r_cfg.wrap_column),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_echo_byte   (o_echo_byte),
        .o_erase_count (o_erase_count),
        .o_last        (o_last)
    );

endmodule

/* src/lewr_checker.sv */
`timescale 1ns / 1ps
module lewr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_action,
    input logic [7:0] o_echo_byte,
    input logic [5:0] o_erase_count,
    input logic       o_last
);

    // a result waiting is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_action) && $stable(o_last))
        else $error("result dropped or changed while stalled");

    // end of input is always the only result of its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == lewr_pkg::ACT_END) |-> o_last)
        else $error("end of input not marked last");

    // echo byte only on echo results
    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action != lewr_pkg::ACT_ECHO) |-> (o_echo_byte == '0))
        else $error("echo byte set on a non-echo result");

    // erase count nonzero and within the line only on erase results
    a_erase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_action == lewr_pkg::ACT_ERASE) ?
            ((o_erase_count != '0) &&
             (o_erase_count <= lewr_pkg::t_cnt'(lewr_pkg::LINE_DEPTH))) :
            (o_erase_count == '0)))
        else $error("erase count out of place");

    // nothing shows right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind line_editor_with_word_wrap lewr_checker u_lewr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_action      (o_action),
    .o_echo_byte   (o_echo_byte),
    .o_erase_count (o_erase_count),
    .o_last        (o_last)
);

/* test/tb_line_editor_with_word_wrap.sv */
`timescale 1ns / 1ps
module tb_line_editor_with_word_wrap;
    import lewr_pkg::*;

    localparam int     HOLD_CYCLES = 400;
    localparam int     TAIL_CYCLES = 320;
    localparam longint LIMIT_NS    = 50_000_000;

    // one edit action as it leaves the block
    typedef struct {
        t_action action;
        t_byte   echo;
        t_cnt    count;
        logic    last;
    } t_edit;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_typed_byte = '0;
    logic       i_out_ready  = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic [2:0] i_cfg_index  = '0;
    logic [7:0] i_cfg_data   = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_action;
    logic [7:0] o_echo_byte;
    logic [5:0] o_erase_count;
    logic       o_last;
    logic       o_cfg_ready;

    // shadow of the editing keys and of the line
    t_cfg        keys = '{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, RST_WRAP};
    t_byte       line_copy[LINE_DEPTH];
    int unsigned col = 0;

    t_edit pending_edits[$];
    int    n_mismatch   = 0;
    bit    no_idle      = 1'b0;
    bit    hold_results = 1'b0;

    line_editor_with_word_wrap i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_typed_byte  (i_typed_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_echo_byte   (o_echo_byte),
        .o_erase_count (o_erase_count),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void emit(t_action a, t_byte b, t_cnt c);
        pending_edits.push_back('{a, b, c, 1'b0});
    endfunction

    // move the last word to a fresh line, or just break when no space is stored
    function automatic void wrap_line();
        int unsigned head;
        int unsigned len;
        head = col;
        while (head > 0 && line_copy[head-1] != SPACE_BYTE)
            head--;
        if (head == 0) begin
            col = 0;
            emit(ACT_NEWLINE, '0, '0);
        end else begin
            len = col - head;
            if (len > 0)
                emit(ACT_ERASE, '0, t_cnt'(len));
            for (int i = 0; i < len; i++)
                line_copy[i] = line_copy[head + i];
            emit(ACT_NEWLINE, '0, '0);
            for (int i = 0; i < len; i++)
                emit(ACT_ECHO, line_copy[i], '0);
            col = len;
        end
    endfunction

    function automatic void predict_edits(t_byte b);
        int unsigned c;
        t_edit       tail;
        if (b == keys.eof_char && col == 0) begin
            emit(ACT_END, '0, '0);
        end else begin
            // editing keys only act on a non-empty line
            if (b == keys.erase_char && col > 0) begin
                col--;
                emit(ACT_ERASE, '0, t_cnt'(1));
            end else if (b == keys.kill_char && col > 0) begin
                emit(ACT_ERASE, '0, t_cnt'(col));
                col = 0;
            end else if (b == keys.word_erase_char && col > 0) begin
                c = col;
                while (c > 0 && line_copy[c-1] == SPACE_BYTE)
                    c--;
                while (c > 0 && line_copy[c-1] != SPACE_BYTE)
                    c--;
                emit(ACT_ERASE, '0, t_cnt'(col - c));
                col = c;
            end else if (b == NEWLINE_BYTE) begin
                col = 0;
                emit(ACT_NEWLINE, '0, '0);
            end else if (b < PRINT_LO || b > PRINT_HI || col >= LINE_DEPTH) begin
                emit(ACT_BELL, '0, '0);
            end else begin
                emit(ACT_ECHO, b, '0);
                line_copy[col] = b;
                col++;
            end
            if (b != SPACE_BYTE && col >= keys.wrap_column)
                wrap_line();
        end
        // flag the final action of this item
        tail = pending_edits.pop_back();
        tail.last = 1'b1;
        pending_edits.push_back(tail);
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void note_mismatch(string what);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t ns mismatch: %s", $time, what);
    endfunction

    always @(posedge i_clk) begin : check_edits
        t_edit want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_edits.size() == 0) begin
                note_mismatch($sformatf("unexpected action %0d echo %02h count %0d last %0b",
                    o_action, o_echo_byte, o_erase_count, o_last));
            end else begin
                want = pending_edits.pop_front();
                if (o_action !== want.action || o_echo_byte !== want.echo ||
                    o_erase_count !== want.count || o_last !== want.last)
                    note_mismatch($sformatf({"expected action %0d echo %02h count %0d last %0b,",
                        " got action %0d echo %02h count %0d last %0b"},
                        want.action, want.echo, want.count, want.last,
                        o_action, o_echo_byte, o_erase_count, o_last));
            end
        end
    end

    // ---------------------------------------------------------------- idling

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side ready, with one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                gap = gap_cycles();
                i_out_ready <= (gap == 0);
                repeat (gap == 0 ? $urandom_range(1, 6) : gap) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(t_byte b);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_typed_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_edits(b);
    endtask

    task automatic type_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(t_byte'(s[i]));
    endtask

    task automatic drain_edits();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_edits.size() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_byte data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_EOF:    keys.eof_char        = data;
            CFG_ERASE:  keys.erase_char      = data;
            CFG_KILL:   keys.kill_char       = data;
            CFG_WERASE: keys.word_erase_char = data;
            CFG_WRAP:   keys.wrap_column     = data[WCOL_W-1:0];
            default:    ;
        endcase
    endtask

    // all registers, then one index that decodes to nothing
    task automatic set_config(t_cfg c);
        do @(posedge i_clk); while (pending_edits.size() != 0);
        write_reg(CFG_EOF, c.eof_char);
        write_reg(CFG_ERASE, c.erase_char);
        write_reg(CFG_KILL, c.kill_char);
        write_reg(CFG_WERASE, c.word_erase_char);
        write_reg(CFG_WRAP, {2'($urandom_range(0, 3)), c.wrap_column});
        write_reg(t_cfg_idx'($urandom_range(CFG_WRAP + 1, (1 << CFG_IDX_W) - 1)),
                  t_byte'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // typing with random words, spaces, editing keys and stray bytes
    function automatic t_byte pick_byte(int edit_pct, int nl_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < edit_pct) begin
            case ($urandom_range(0, 3))
                0:       return keys.eof_char;
                1:       return keys.erase_char;
                2:       return keys.kill_char;
                default: return keys.word_erase_char;
            endcase
        end
        if (r < edit_pct + nl_pct)
            return NEWLINE_BYTE;
        if (r < edit_pct + nl_pct + 6)
            return t_byte'($urandom_range(0, 255));
        if (r < edit_pct + nl_pct + 22)
            return SPACE_BYTE;
        return t_byte'($urandom_range(PRINT_LO + 1, PRINT_HI));
    endfunction

    task automatic run_random(int n_items, int edit_pct, int nl_pct);
        for (int i = 0; i < n_items; i++) begin
            if (i % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_byte(pick_byte(edit_pct, nl_pct));
        end
        no_idle = 1'b0;
        drain_edits();
    endtask

    function automatic t_cfg random_keys(t_wcol wrap);
        return '{t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                 t_byte'($urandom), wrap};
    endfunction

    // ---------------------------------------------------------------- tests

    // default keys, empty line fall-through, bells, word erase over spaces
    task automatic test_editing_keys();
        send_byte(RST_EOF);
        send_byte(RST_ERASE);
        send_byte(RST_KILL);
        send_byte(RST_WERASE);
        send_byte(NEWLINE_BYTE);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        type_text(" b~");
        send_byte(RST_EOF);
        send_byte(RST_WERASE);
        type_text("c");
        send_byte(RST_WERASE);
        send_byte(RST_WERASE);
        type_text("xy");
        send_byte(RST_ERASE);
        send_byte(RST_KILL);
        drain_edits();
    endtask

    // word moved to next line, bare break without a space, wrap at column zero
    task automatic test_word_wrap();
        set_config('{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, 6'd4});
        type_text("a bc  x");
        send_byte(RST_ERASE);
        type_text("wxyz");
        drain_edits();
        set_config('{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, 6'd0});
        type_text("q ");
        send_byte(RST_EOF);
        send_byte(RST_EOF);
        drain_edits();
    endtask

    // long hold on the result side while items keep coming
    task automatic test_output_stall();
        set_config('{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, 6'd8});
        hold_results = 1'b1;
        for (int i = 0; i < 30; i++)
            send_byte(pick_byte(8, 3));
        drain_edits();
    endtask

    // wrapping off and few edits so the line fills up
    task automatic test_full_line();
        set_config('{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, 6'd63});
        run_random(80, 1, 0);
    endtask

    task automatic test_register_extremes();
        set_config('{8'h00, 8'hFF, SPACE_BYTE, PRINT_HI, 6'd48});
        run_random(60, 10, 3);
        set_config('{8'hFF, 8'h08, 8'h15, 8'h77, 6'd0});
        run_random(45, 10, 3);
        set_config('{RST_EOF, RST_ERASE, RST_KILL, RST_WERASE, 6'd1});
        run_random(40, 10, 3);
    endtask

    task automatic test_random_editing();
        set_config(random_keys(t_wcol'($urandom_range(1, 48))));
        run_random(70, 12, 3);
        set_config(random_keys(t_wcol'($urandom_range(2, 12))));
        run_random(70, 12, 3);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_editing_keys();
        test_word_wrap();
        test_output_stall();
        test_full_line();
        test_register_extremes();
        test_random_editing();
        drain_edits();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && pending_edits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
